// File: src/assert_macros.svh
// assertion macros used by the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, quiet while reset is held
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcw checker: property failed");

// condition that must never be seen
`define TCW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `TCW_ASSERT(lbl, clk, rst_n, !(expr))

`endif

// File: src/tcw_pkg.sv
// shared types and constants of the text console writer
`default_nettype none

package tcw_pkg;

  localparam int IDX_W = 11;
  localparam int POS_W = 11;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  // finish strobe from the sequencer to the result register
  typedef struct packed {
    logic valid;
    logic rd_hit;
  } tcw_done_t;

endpackage

`default_nettype wire

// File: src/tcw_screen_ram.sv
// screen cell store: one write port, one registered read port
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/tcw_ctrl.sv
// sequencer: cursor, clearing pass, puts, reads and the scroll sweep
`default_nettype none

module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int MAW    = $clog2(COLUMNS * ROWS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_cmd,
  input  wire logic [7:0]               in_char_code,
  input  wire logic [7:0]               in_attribute,
  input  wire logic [tcw_pkg::IDX_W-1:0] in_cell_index,
  input  wire logic                     out_free,
  output tcw_pkg::tcw_done_t            done,
  output logic [tcw_pkg::POS_W-1:0]     cursor_pos,
  output logic                          mem_we,
  output logic [MAW-1:0]                mem_waddr,
  output logic [15:0]                   mem_wdata,
  output logic                          mem_re,
  output logic [MAW-1:0]                mem_raddr,
  input  wire logic [15:0]              mem_rdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS + 1);
  localparam int CLW   = $clog2(COLUMNS + 1);
  localparam int COLW  = $clog2(COLUMNS);
  localparam int CMPW  = ((AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   cursor_r, cursor_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [7:0]      attr_r, attr_nxt;
  logic            rd_hit_r, rd_hit_nxt;
  logic            cp_pend_r, cp_pend_nxt;
  logic [MAW-1:0]  cp_waddr_r, cp_waddr_nxt;

  logic [CLW-1:0]  step;
  logic [AW-1:0]   cur_calc;
  logic [COLW-1:0] col_inc;
  logic            idx_hit;

  assign step     = CLW'(COLUMNS) - CLW'(col_r);
  assign col_inc  = (col_r == COLW'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
  assign idx_hit  = CMPW'(in_cell_index) < CMPW'(CELLS);
  assign cursor_pos = tcw_pkg::POS_W'(cursor_r);

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    cursor_nxt   = cursor_r;
    col_nxt      = col_r;
    attr_nxt     = attr_r;
    rd_hit_nxt   = rd_hit_r;
    cp_pend_nxt  = cp_pend_r;
    cp_waddr_nxt = cp_waddr_r;
    cur_calc     = cursor_r;
    in_ready     = 1'b0;
    done         = '0;
    mem_we       = 1'b0;
    mem_waddr    = MAW'(addr_r);
    mem_wdata    = {8'h00, tcw_pkg::SPACE_CHAR};
    mem_re       = 1'b0;
    mem_raddr    = MAW'(addr_r);

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == AW'(CELLS - 1)) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          attr_nxt = in_attribute;
          if (in_cmd == tcw_pkg::CMD_READ) begin
            mem_re     = idx_hit;
            mem_raddr  = MAW'(in_cell_index);
            rd_hit_nxt = idx_hit;
            state_nxt  = ST_FINISH;
          end else begin
            rd_hit_nxt = 1'b0;
            if (in_char_code == tcw_pkg::NEWLINE_CHAR) begin
              cur_calc = cursor_r + AW'(step);
              col_nxt  = '0;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = MAW'(cursor_r);
              mem_wdata = {in_attribute, in_char_code};
              cur_calc  = cursor_r + 1'b1;
              col_nxt   = col_inc;
            end
            // cursor can only land exactly on the screen end
            if (cur_calc == AW'(CELLS)) begin
              cursor_nxt  = AW'(CELLS - COLUMNS);
              addr_nxt    = AW'(COLUMNS);
              cp_pend_nxt = 1'b0;
              state_nxt   = ST_SCROLL;
            end else begin
              cursor_nxt = cur_calc;
              state_nxt  = ST_FINISH;
            end
          end
        end
      end

      ST_SCROLL: begin
        // read cell i, write it one row up on the following cycle
        mem_we    = cp_pend_r;
        mem_waddr = cp_waddr_r;
        mem_wdata = mem_rdata;
        if (addr_r == AW'(CELLS)) begin
          cp_pend_nxt = 1'b0;
          addr_nxt    = AW'(CELLS - COLUMNS);
          state_nxt   = ST_BLANK;
        end else begin
          mem_re       = 1'b1;
          cp_pend_nxt  = 1'b1;
          cp_waddr_nxt = MAW'(addr_r - AW'(COLUMNS));
          addr_nxt     = addr_r + 1'b1;
        end
      end

      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {attr_r, tcw_pkg::SPACE_CHAR};
        if (addr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          done.valid  = 1'b1;
          done.rd_hit = rd_hit_r;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      addr_r    <= '0;
      cursor_r  <= '0;
      col_r     <= '0;
      rd_hit_r  <= 1'b0;
      cp_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      cursor_r  <= cursor_nxt;
      col_r     <= col_nxt;
      rd_hit_r  <= rd_hit_nxt;
      cp_pend_r <= cp_pend_nxt;
    end
    attr_r     <= attr_nxt;
    cp_waddr_r <= cp_waddr_nxt;
  end

endmodule

`default_nettype wire

// File: src/text_console_writer.sv
// Text console writer: 80x25 character cell screen with cursor and scroll.
// Input channel in_*: in_cmd selects a put of in_char_code/in_attribute at
// the cursor, or a read of cell in_cell_index. Newline moves the cursor to
// the next row start. Every item gives one beat on out_*: the read cell (zero
// for puts and for indexes off the screen) and the cursor after the item.
// After reset the screen is swept to spaces with attribute zero, one cell a
// cycle, and in_ready stays low until that sweep ends. A new item is taken
// only once the last one has gone to the result register; the screen store
// has one write and one registered read port. A put that runs off the screen
// end scrolls: the copy sweep and the row blank go through these ports one
// cell a cycle. Items are taken one at a time. A finished result waits in
// the output register while the next item is accepted; if the receiver
// still stalls when that item finishes, the block holds it and in_ready
// stays low.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_cmd,
  input  wire logic [7:0]                in_char_code,
  input  wire logic [7:0]                in_attribute,
  input  wire logic [tcw_pkg::IDX_W-1:0] in_cell_index,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_cell_char,
  output logic [7:0]                     out_cell_attr,
  output logic [tcw_pkg::POS_W-1:0]      out_cursor_pos
);

  localparam int MAW = $clog2(COLUMNS * ROWS);

  tcw_pkg::tcw_done_t          done;
  logic [tcw_pkg::POS_W-1:0]   cursor_pos;
  logic                        mem_we;
  logic [MAW-1:0]              mem_waddr;
  logic [15:0]                 mem_wdata;
  logic                        mem_re;
  logic [MAW-1:0]              mem_raddr;
  logic [15:0]                 mem_rdata;

  logic                        out_valid_r;
  logic [7:0]                  cell_char_r;
  logic [7:0]                  cell_attr_r;
  logic [tcw_pkg::POS_W-1:0]   cursor_pos_r;
  logic                        out_free;

  assign out_free = !out_valid_r || out_ready;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_attribute  (in_attribute),
    .in_cell_index (in_cell_index),
    .out_free      (out_free),
    .done          (done),
    .cursor_pos    (cursor_pos),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  tcw_screen_ram #(
    .DEPTH (COLUMNS * ROWS),
    .AW    (MAW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register, loaded only when it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (done.valid) begin
      cell_char_r  <= done.rd_hit ? mem_rdata[7:0]  : 8'h00;
      cell_attr_r  <= done.rd_hit ? mem_rdata[15:8] : 8'h00;
      cursor_pos_r <= cursor_pos;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = cell_char_r;
  assign out_cell_attr  = cell_attr_r;
  assign out_cursor_pos = cursor_pos_r;

endmodule

`default_nettype wire

// File: src/tcw_checker.sv
// port level checker for the text console writer, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [7:0]                out_cell_char,
  input wire logic [7:0]                out_cell_attr,
  input wire logic [tcw_pkg::POS_W-1:0] out_cursor_pos
);

  localparam int CELLS = COLUMNS * ROWS;

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pend_r, pend_nxt;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;
  assign pend_nxt = pend_r + {1'b0, in_beat} - {1'b0, out_beat};

  // items taken minus results delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `TCW_ASSERT(a_busy_after_accept, clk, rst_n, in_beat |=> !in_ready)
  `TCW_ASSERT(a_cursor_on_screen, clk, rst_n, out_valid |-> (32'(out_cursor_pos) < CELLS))
  `TCW_ASSERT(a_result_backed, clk, rst_n, out_valid |-> (pend_r != 2'd0))
  `TCW_ASSERT_NEVER(a_outstanding_bound, clk, rst_n, pend_r == 2'd3)
  `TCW_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable({out_cell_char, out_cell_attr, out_cursor_pos})))

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

// File: tb/sv/tb_text_console_writer.sv
// testbench for the text console writer: directed table, random traffic, scoreboard check
`timescale 1ns / 100ps

module tb_text_console_writer;

  localparam int COLS          = 80;
  localparam int ROWS_N        = 25;
  localparam int CELLS         = COLS * ROWS_N;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int TAIL_ITEMS    = 150;
  localparam int N_DIRECTED    = 13;
  // worst case: every item scrolls behind the longest gap and stall, after the reset sweep
  localparam int CYCLE_LIMIT   = 12_000_000;

  typedef struct packed {
    logic [7:0]                cell_char;
    logic [7:0]                cell_attr;
    logic [tcw_pkg::POS_W-1:0] cursor_pos;
  } cell_result_t;

  typedef struct {
    logic                      cmd;
    logic [7:0]                char_code;
    logic [7:0]                attribute;
    logic [tcw_pkg::IDX_W-1:0] cell_index;
    int                        reps;
    bit                        typed;
    cell_result_t              want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_cmd = tcw_pkg::CMD_PUT;
  logic [7:0]                in_char_code = 8'h00;
  logic [7:0]                in_attribute = 8'h00;
  logic [tcw_pkg::IDX_W-1:0] in_cell_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                out_cell_char;
  logic [7:0]                out_cell_attr;
  logic [tcw_pkg::POS_W-1:0] out_cursor_pos;

  // shadow of the screen and cursor
  logic [15:0]  screen_shadow [0:CELLS-1];
  int unsigned  cursor_cell;

  cell_result_t pending_results [$];
  cell_result_t oldest_result;
  stim_row_t    directed_rows [N_DIRECTED];

  bit idling_on = 1'b1;
  int fail_count = 0;
  int cycle_count = 0;
  int results_checked = 0;
  int puts_sent = 0;
  int newlines_sent = 0;
  int reads_sent = 0;
  int scroll_count = 0;

  text_console_writer #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_attribute  (in_attribute),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .out_cursor_pos(out_cursor_pos)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("text_console_writer test failed");
      $finish;
    end
  end

  // applies one item to the shadow screen and returns the beat it should produce
  function automatic cell_result_t console_step(input logic cmd, input logic [7:0] ch,
                                                input logic [7:0] attr,
                                                input logic [tcw_pkg::IDX_W-1:0] idx);
    cell_result_t res;
    res = '0;
    if (cmd == tcw_pkg::CMD_READ) begin
      if (idx < CELLS) begin
        res.cell_char = screen_shadow[idx][7:0];
        res.cell_attr = screen_shadow[idx][15:8];
      end
    end else begin
      if (cursor_cell >= CELLS) cursor_cell = 0;
      if (ch == tcw_pkg::NEWLINE_CHAR) begin
        cursor_cell += COLS - (cursor_cell % COLS);
      end else begin
        screen_shadow[cursor_cell] = {attr, ch};
        cursor_cell++;
      end
      if (cursor_cell >= CELLS) begin
        for (int i = COLS; i < CELLS; i++) screen_shadow[i-COLS] = screen_shadow[i];
        // blanked row takes the attribute of the item, newline included
        for (int i = CELLS - COLS; i < CELLS; i++) begin
          screen_shadow[i] = {attr, tcw_pkg::SPACE_CHAR};
        end
        cursor_cell -= COLS;
        scroll_count++;
      end
    end
    res.cursor_pos = cursor_cell[tcw_pkg::POS_W-1:0];
    return res;
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [7:0] attr,
                           input logic [tcw_pkg::IDX_W-1:0] idx, input bit typed,
                           input cell_result_t want);
    cell_result_t predicted;
    if (idling_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_char_code  <= ch;
    in_attribute  <= attr;
    in_cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = console_step(cmd, ch, attr, idx);
    pending_results.push_back(typed ? want : predicted);
    if (cmd == tcw_pkg::CMD_READ) reads_sent++;
    else if (ch == tcw_pkg::NEWLINE_CHAR) newlines_sent++;
    else puts_sent++;
  endtask

  // result side: stalls come in bursts while idling is on
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: char %02h attr %02h cursor %0d",
               out_cell_char, out_cell_attr, out_cursor_pos);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        if (out_cell_char !== oldest_result.cell_char) begin
          $error("cell_char mismatch: expected %02h, got %02h",
                 oldest_result.cell_char, out_cell_char);
          fail_count++;
        end
        if (out_cell_attr !== oldest_result.cell_attr) begin
          $error("cell_attr mismatch: expected %02h, got %02h",
                 oldest_result.cell_attr, out_cell_attr);
          fail_count++;
        end
        if (out_cursor_pos !== oldest_result.cursor_pos) begin
          $error("cursor_pos mismatch: expected %0d, got %0d",
                 oldest_result.cursor_pos, out_cursor_pos);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int                         pick;
    int                         back;
    logic [31:0]                rnd;
    logic [7:0]                 ch;
    logic [7:0]                 attr;
    logic [tcw_pkg::IDX_W-1:0]  idx;

    // cmd, char, attr, index, repeats, typed, expected beat
    directed_rows[0]  = '{tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd0, 1, 1'b1,
                          {tcw_pkg::SPACE_CHAR, 8'h00, 11'd0}};
    directed_rows[1]  = '{tcw_pkg::CMD_READ, 8'hff, 8'hff, 11'd2047, 1, 1'b1,
                          {8'h00, 8'h00, 11'd0}};
    directed_rows[2]  = '{tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd2000, 1, 1'b1,
                          {8'h00, 8'h00, 11'd0}};
    directed_rows[3]  = '{tcw_pkg::CMD_PUT, 8'h41, 8'h07, 11'd0, 1, 1'b1,
                          {8'h00, 8'h00, 11'd1}};
    directed_rows[4]  = '{tcw_pkg::CMD_PUT, 8'hff, 8'hff, 11'd2047, 1, 1'b1,
                          {8'h00, 8'h00, 11'd2}};
    directed_rows[5]  = '{tcw_pkg::CMD_PUT, 8'h00, 8'h00, 11'd0, 1, 1'b1,
                          {8'h00, 8'h00, 11'd3}};
    directed_rows[6]  = '{tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd1, 1, 1'b1,
                          {8'hff, 8'hff, 11'd3}};
    // walk the cursor down to the start of the last row
    directed_rows[7]  = '{tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CHAR, 8'h00, 11'd0, 24, 1'b0,
                          '0};
    // newline on the last row scrolls and blanks it in its own attribute
    directed_rows[8]  = '{tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CHAR, 8'h5a, 11'd0, 1, 1'b1,
                          {8'h00, 8'h00, 11'd1920}};
    directed_rows[9]  = '{tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd1999, 1, 1'b1,
                          {tcw_pkg::SPACE_CHAR, 8'h5a, 11'd1920}};
    directed_rows[10] = '{tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd0, 1, 1'b0, '0};
    directed_rows[11] = '{tcw_pkg::CMD_PUT, 8'h7e, 8'h80, 11'd5, 1, 1'b1,
                          {8'h00, 8'h00, 11'd1921}};
    directed_rows[12] = '{tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd1920, 1, 1'b1,
                          {8'h7e, 8'h80, 11'd1921}};

    for (int i = 0; i < CELLS; i++) screen_shadow[i] = {8'h00, tcw_pkg::SPACE_CHAR};
    cursor_cell = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      repeat (directed_rows[r].reps)
        send_item(directed_rows[r].cmd, directed_rows[r].char_code,
                  directed_rows[r].attribute, directed_rows[r].cell_index,
                  directed_rows[r].typed, directed_rows[r].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - TAIL_ITEMS) idling_on = 1'b0;
      else if (n % 100 == 0) idling_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      rnd  = $urandom_range(0, 2047);
      idx  = rnd[tcw_pkg::IDX_W-1:0];
      rnd  = $urandom;
      ch   = rnd[7:0];
      attr = rnd[15:8];
      if (pick < 40) begin
        // half of the reads land near the cursor where text was just written
        back = $urandom_range(0, 2 * COLS);
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          rnd = (cursor_cell > back) ? cursor_cell - back : 0;
          idx = rnd[tcw_pkg::IDX_W-1:0];
        end else if (pick < 9) begin
          rnd = $urandom_range(0, CELLS - 1);
          idx = rnd[tcw_pkg::IDX_W-1:0];
        end
        send_item(tcw_pkg::CMD_READ, ch, attr, idx, 1'b0, '0);
      end else if (pick < 44) begin
        send_item(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CHAR, attr, idx, 1'b0, '0);
      end else begin
        send_item(tcw_pkg::CMD_PUT, ch, attr, idx, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d character puts, %0d newlines and %0d cell reads, %0d scrolls",
             puts_sent, newlines_sent, reads_sent, scroll_count);
    $display("%0d result beats compared in %0d cycles", results_checked, cycle_count);
    if (fail_count == 0) begin
      $display("text_console_writer test passed");
    end else begin
      $display("text_console_writer test failed");
    end
    $finish;
  end

endmodule
